// File: design/rcp_pkg.sv
// Shared types and codes for the reified cardinality propagator.
// Depends on nothing; used by the lane, front, merge and top modules.
package rcp_pkg;

	// Variables handled by one counting lane
	localparam int LANE_W = 8;
	localparam int CNT_W  = $clog2(LANE_W + 1);

	// Verdict codes
	localparam logic [1:0] V_FAIL = 2'd0;
	localparam logic [1:0] V_DONE = 2'd1;
	localparam logic [1:0] V_PEND = 2'd2;

	// Flag codes
	localparam logic [1:0] F_UNK   = 2'd0;
	localparam logic [1:0] F_FALSE = 2'd1;
	localparam logic [1:0] F_TRUE  = 2'd2;

	// Commands for the unfixed variables
	localparam logic [1:0] IMP_NONE = 2'd0;
	localparam logic [1:0] IMP_ZERO = 2'd1;
	localparam logic [1:0] IMP_ONE  = 2'd2;

	// Bound checks and narrowing that need no counts
	typedef struct packed {
		logic        fail;
		logic        done_false;
		logic [1:0]  flag;
		logic [6:0]  n;
		logic [15:0] low_min;
		logic [15:0] low_max;
		logic [15:0] up_min;
		logic [15:0] up_max;
		logic [15:0] low_max_n;
		logic [15:0] up_min_n;
	} front_t;

	// One result beat
	typedef struct packed {
		logic [1:0]  verdict;
		logic [1:0]  flag;
		logic [1:0]  impose;
		logic [15:0] low_min;
		logic [15:0] low_max;
		logic [15:0] up_min;
		logic [15:0] up_max;
	} result_t;

endpackage

// File: design/reified_cardinality_propagator_unit.sv
// Reified cardinality propagator: one propagation step per input beat, with
// a new beat taken every cycle while the input is not stalled. A beat passes
// two register stages: the lane counts and front checks are registered into
// the first stage when the beat is accepted, then the merge decision is
// registered into the output register and presented there until taken. The
// output stall holds a waiting result and, behind it, a full first stage; an
// empty first stage still takes a beat, so the stall reaches the input only
// when both stages are full.
// Depends on rcp_pkg, rcp_lane, rcp_front and rcp_merge.
module reified_cardinality_propagator_unit #(
	parameter int MAX_VARS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] fixed_mask,
	input  logic [63:0] value_mask,
	input  logic [6:0]  var_count,
	input  logic [15:0] low_min,
	input  logic [15:0] low_max,
	input  logic [15:0] up_min,
	input  logic [15:0] up_max,
	input  logic [1:0]  flag_state,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  verdict,
	output logic [1:0]  flag_result,
	output logic [1:0]  impose,
	output logic [15:0] low_min_out,
	output logic [15:0] low_max_out,
	output logic [15:0] up_min_out,
	output logic [15:0] up_max_out
);
	import rcp_pkg::*;

	localparam int NUM_LANES = (MAX_VARS + LANE_W - 1) / LANE_W;

	front_t            front;
	front_t            front_s1;
	logic [CNT_W-1:0]  ones [NUM_LANES];
	logic [CNT_W-1:0]  zeroes [NUM_LANES];
	logic [CNT_W-1:0]  ones_s1 [NUM_LANES];
	logic [CNT_W-1:0]  zeroes_s1 [NUM_LANES];
	result_t           result;
	result_t           result_s2;
	logic              valid_s1;
	logic              valid_s2;
	logic              load_s2;
	logic              adv_s1;

	// Front checks on the bounds and flag
	rcp_front #(
		.MAX_VARS(MAX_VARS)
	) u_front (
		.var_count (var_count),
		.low_min   (low_min),
		.low_max   (low_max),
		.up_min    (up_min),
		.up_max    (up_max),
		.flag_state(flag_state),
		.front     (front)
	);

	// Counting lanes side by side
	for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
		rcp_lane #(
			.BASE(l * LANE_W)
		) u_lane (
			.fixed_bits(fixed_mask[l*LANE_W +: LANE_W]),
			.value_bits(value_mask[l*LANE_W +: LANE_W]),
			.n         (front.n),
			.ones      (ones[l]),
			.zeroes    (zeroes[l])
		);
	end

	// Combine lane counts and decide
	rcp_merge #(
		.NUM_LANES(NUM_LANES)
	) u_merge (
		.front      (front_s1),
		.lane_ones  (ones_s1),
		.lane_zeroes(zeroes_s1),
		.result     (result)
	);

	// Advance a stage when the one after it is empty or moving
	assign load_s2  = !valid_s2 || !out_stall;
	assign adv_s1   = !valid_s1 || load_s2;
	assign in_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) valid_s1 <= in_valid;
			if (load_s2) valid_s2 <= valid_s1;
		end
	end

	// Capture lane counts and front checks
	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			front_s1  <= front;
			ones_s1   <= ones;
			zeroes_s1 <= zeroes;
		end
	end

	// Hold the result beat until taken
	always_ff @(posedge clk) begin
		if (load_s2 && valid_s1) begin
			result_s2 <= result;
		end
	end

	assign out_valid   = valid_s2;
	assign verdict     = result_s2.verdict;
	assign flag_result = result_s2.flag;
	assign impose      = result_s2.impose;
	assign low_min_out = result_s2.low_min;
	assign low_max_out = result_s2.low_max;
	assign up_min_out  = result_s2.up_min;
	assign up_max_out  = result_s2.up_max;

`ifndef ASSERT_OFF
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_stall))
		else $error("input stalled with room in the pipeline");

	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> valid_s1)
		else $error("accepted beat lost from first stage");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !out_stall && !valid_s1) |=> !out_valid)
		else $error("result beat repeated");

	a_fail_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (verdict == V_FAIL)) |-> (impose == IMP_NONE))
		else $error("command given on failure");

	a_cmd_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (impose != IMP_NONE)) |-> (verdict == V_DONE))
		else $error("command given without entailment");
`endif

endmodule

// File: design/rcp_lane.sv
// One counting lane: counts fixed ones and fixed zeroes among LANE_W variables.
// Depends on rcp_pkg.
module rcp_lane #(
	parameter int BASE = 0
) (
	input  logic [rcp_pkg::LANE_W-1:0] fixed_bits,
	input  logic [rcp_pkg::LANE_W-1:0] value_bits,
	input  logic [6:0]                 n,
	output logic [rcp_pkg::CNT_W-1:0]  ones,
	output logic [rcp_pkg::CNT_W-1:0]  zeroes
);
	import rcp_pkg::*;

	logic [LANE_W-1:0] in_use;

	// Mark the variables below the count
	always_comb begin
		for (int j = 0; j < LANE_W; j++) begin
			in_use[j] = (8'(BASE + j) < {1'b0, n});
		end
	end

	// Count ones and zeroes among the used, fixed variables
	always_comb begin
		ones   = '0;
		zeroes = '0;
		for (int j = 0; j < LANE_W; j++) begin
			ones   = ones + CNT_W'(in_use[j] & fixed_bits[j] & value_bits[j]);
			zeroes = zeroes + CNT_W'(in_use[j] & fixed_bits[j] & ~value_bits[j]);
		end
	end

endmodule

// File: design/rcp_front.sv
// Front checks: clamps the variable count, checks the intervals and applies
// the narrowing of a true flag. Depends on rcp_pkg.
module rcp_front #(
	parameter int MAX_VARS = 64
) (
	input  logic [6:0]      var_count,
	input  logic [15:0]     low_min,
	input  logic [15:0]     low_max,
	input  logic [15:0]     up_min,
	input  logic [15:0]     up_max,
	input  logic [1:0]      flag_state,
	output rcp_pkg::front_t front
);
	import rcp_pkg::*;

	logic [1:0]  flag;
	logic [15:0] lmax_n;
	logic [15:0] umin_n;

	always_comb begin
		// Treat the unused flag code as unknown
		flag = (flag_state == 2'd3) ? F_UNK : flag_state;

		// Narrow low from above and up from below when the flag is true
		lmax_n = low_max;
		umin_n = up_min;
		if (flag == F_TRUE) begin
			if (low_max > up_max) lmax_n = up_max;
			if (up_min < low_min) umin_n = low_min;
		end

		front.flag      = flag;
		front.n         = (var_count > 7'(MAX_VARS)) ? 7'(MAX_VARS) : var_count;
		front.low_min   = low_min;
		front.low_max   = low_max;
		front.up_min    = up_min;
		front.up_max    = up_max;
		front.low_max_n = lmax_n;
		front.up_min_n  = umin_n;

		// Fail on no variables or an empty interval, before or after narrowing
		front.fail = (var_count == 7'd0) || (low_min > low_max) || (up_min > up_max)
			|| ((flag == F_TRUE) && ((low_min > lmax_n) || (umin_n > up_max)));
		// Unknown flag with low above up cannot hold
		front.done_false = (flag == F_UNK) && (low_min > up_max);
	end

endmodule

// File: design/rcp_merge.sv
// Merge stage: adds the lane counts and decides verdict, flag, command and
// narrowed bounds. Depends on rcp_pkg.
module rcp_merge #(
	parameter int NUM_LANES = 8
) (
	input  rcp_pkg::front_t              front,
	input  logic [rcp_pkg::CNT_W-1:0]    lane_ones [NUM_LANES],
	input  logic [rcp_pkg::CNT_W-1:0]    lane_zeroes [NUM_LANES],
	output rcp_pkg::result_t             result
);
	import rcp_pkg::*;

	logic [6:0]  ones;
	logic [6:0]  zeroes;
	logic [16:0] ones_w;
	logic [16:0] poss_w;
	logic        has_free;
	logic [16:0] lmin_w;
	logic [16:0] lmax_w;
	logic [16:0] umin_w;
	logic [16:0] umax_w;
	logic [16:0] lmax_t;
	logic [16:0] umin_t;
	logic [16:0] lmin_f;
	logic [16:0] umax_f;
	logic        bad;

	// Add up the lane counts
	always_comb begin
		ones   = '0;
		zeroes = '0;
		for (int l = 0; l < NUM_LANES; l++) begin
			ones   = ones + 7'(lane_ones[l]);
			zeroes = zeroes + 7'(lane_zeroes[l]);
		end
	end

	assign ones_w   = {10'd0, ones};
	assign poss_w   = {10'd0, front.n} - {10'd0, zeroes};
	assign has_free = (poss_w > ones_w);
	assign lmin_w   = {1'b0, front.low_min};
	assign lmax_w   = {1'b0, front.low_max_n};
	assign umin_w   = {1'b0, front.up_min_n};
	assign umax_w   = {1'b0, front.up_max};

	// Decide the result; failure echoes the received bounds
	always_comb begin
		lmax_t = lmax_w;
		umin_t = umin_w;
		lmin_f = lmin_w;
		umax_f = umax_w;
		bad    = 1'b0;

		result.verdict = V_FAIL;
		result.flag    = front.flag;
		result.impose  = IMP_NONE;
		result.low_min = front.low_min;
		result.low_max = front.low_max;
		result.up_min  = front.up_min;
		result.up_max  = front.up_max;

		priority if (front.fail) begin
			result.verdict = V_FAIL;
		end else if (front.done_false) begin
			result.verdict = V_DONE;
			result.flag    = F_FALSE;
		end else if ((ones_w > umax_w) || (poss_w < lmin_w)) begin
			// Count cannot reach the bounds
			if (front.flag != F_TRUE) begin
				result.verdict = V_DONE;
				result.flag    = F_FALSE;
				result.low_max = lmax_w[15:0];
				result.up_min  = umin_w[15:0];
			end
		end else if ((ones_w >= lmax_w) && (poss_w <= umin_w)) begin
			// Count is certain to lie within the bounds
			if (front.flag != F_FALSE) begin
				result.verdict = V_DONE;
				result.flag    = F_TRUE;
				result.low_max = lmax_w[15:0];
				result.up_min  = umin_w[15:0];
			end
		end else if (front.flag == F_TRUE) begin
			priority if ((ones_w == umax_w) && has_free) begin
				result.verdict = V_DONE;
				result.impose  = IMP_ZERO;
				result.low_max = lmax_w[15:0];
				result.up_min  = umin_w[15:0];
			end else if ((poss_w == lmin_w) && has_free) begin
				result.verdict = V_DONE;
				result.impose  = IMP_ONE;
				result.low_max = lmax_w[15:0];
				result.up_min  = umin_w[15:0];
			end else begin
				// Tighten low from above and up from below by the counts
				if (lmax_w > poss_w) lmax_t = poss_w;
				if (umin_w < ones_w) umin_t = ones_w;
				if (!((lmin_w > lmax_t) || (umin_t > umax_w))) begin
					result.verdict = V_PEND;
					result.low_max = lmax_t[15:0];
					result.up_min  = umin_t[15:0];
				end
			end
		end else if (front.flag == F_FALSE) begin
			priority if (((ones_w + 17'd1) == lmin_w) && (poss_w <= umin_w) && has_free) begin
				result.verdict = V_DONE;
				result.impose  = IMP_ZERO;
			end else if ((poss_w == (umin_w + 17'd1)) && (ones_w >= lmax_w) && has_free) begin
				result.verdict = V_DONE;
				result.impose  = IMP_ONE;
			end else begin
				// Keep up below the possible count while low is already met
				if (lmax_w <= ones_w) begin
					if (poss_w == 17'd0) begin
						bad = 1'b1;
					end else begin
						if (umax_w > (poss_w - 17'd1)) umax_f = poss_w - 17'd1;
						if (umin_w > umax_f) bad = 1'b1;
					end
				end
				// Push low above the fixed ones while up is already met
				if (umin_w >= poss_w) begin
					if (lmin_w < (ones_w + 17'd1)) lmin_f = ones_w + 17'd1;
					if (lmin_f > lmax_w) bad = 1'b1;
				end
				if (!bad) begin
					result.verdict = V_PEND;
					result.low_min = lmin_f[15:0];
					result.up_max  = umax_f[15:0];
				end
			end
		end else begin
			result.verdict = V_PEND;
		end
	end

endmodule

// File: tb/tb_reified_cardinality_propagator_unit.sv
`timescale 1ns / 1ps
// Testbench for reified_cardinality_propagator_unit: directed and random propagation
// requests, with an in-bench predictor and a scoreboard that checks every result beat.
// Depends on rcp_pkg and the design top level only.

import rcp_pkg::*;

// One request beat as seen on the input ports
typedef struct packed {
	logic [63:0] fixed_bits;
	logic [63:0] value_bits;
	logic [6:0]  count;
	logic [15:0] lo_min;
	logic [15:0] lo_max;
	logic [15:0] hi_min;
	logic [15:0] hi_max;
	logic [1:0]  flag;
} request_t;

class propagation_checker;
	localparam int VAR_LIMIT = 64;

	result_t expected_q[$];
	int      errors;

	function new();
		errors = 0;
	endfunction

	function result_t settle(logic [1:0] v, logic [1:0] f, logic [1:0] imp,
		int ll, int lu, int ul, int uu);
		result_t r;
		r.verdict = v;
		r.flag    = f;
		r.impose  = imp;
		r.low_min = 16'(ll);
		r.low_max = 16'(lu);
		r.up_min  = 16'(ul);
		r.up_max  = 16'(uu);
		return r;
	endfunction

	// Work out the result of one propagation step
	function result_t propagate_step(request_t rq);
		result_t     failed;
		logic [63:0] used, fx;
		logic [1:0]  b;
		int n, ll, lu, ul, uu, ones, zeroes, poss, freev;
		b = (rq.flag > F_TRUE) ? F_UNK : rq.flag;
		ll = rq.lo_min;
		lu = rq.lo_max;
		ul = rq.hi_min;
		uu = rq.hi_max;
		failed = settle(V_FAIL, b, IMP_NONE, ll, lu, ul, uu);
		n = rq.count;
		if (n > VAR_LIMIT)
			n = VAR_LIMIT;
		if (n == 0 || ll > lu || ul > uu)
			return failed;
		used = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
		fx = rq.fixed_bits & used;

		// Tighten the bounds when b is known true; decide early when b is open
		if (b == F_TRUE) begin
			if (lu > uu) lu = uu;
			if (ul < ll) ul = ll;
			if (ll > lu || ul > uu)
				return failed;
		end else if (b == F_UNK && ll > uu) begin
			return settle(V_DONE, F_FALSE, IMP_NONE, ll, lu, ul, uu);
		end

		ones   = $countones(fx & rq.value_bits);
		zeroes = $countones(fx & ~rq.value_bits);
		poss   = n - zeroes;
		freev  = poss - ones;

		// Count surely outside the bounds
		if (ones > uu || poss < ll) begin
			if (b == F_TRUE)
				return failed;
			return settle(V_DONE, F_FALSE, IMP_NONE, ll, lu, ul, uu);
		end
		// Count surely inside the bounds
		if (ones >= lu && poss <= ul) begin
			if (b == F_FALSE)
				return failed;
			return settle(V_DONE, F_TRUE, IMP_NONE, ll, lu, ul, uu);
		end

		if (b == F_TRUE) begin
			if (ones == uu && freev > 0)
				return settle(V_DONE, b, IMP_ZERO, ll, lu, ul, uu);
			if (poss == ll && freev > 0)
				return settle(V_DONE, b, IMP_ONE, ll, lu, ul, uu);
			if (lu > poss) lu = poss;
			if (ul < ones) ul = ones;
			if (ll > lu || ul > uu)
				return failed;
		end else if (b == F_FALSE) begin
			if (ones + 1 == ll && poss <= ul && freev > 0)
				return settle(V_DONE, b, IMP_ZERO, ll, lu, ul, uu);
			if (poss == ul + 1 && ones >= lu && freev > 0)
				return settle(V_DONE, b, IMP_ONE, ll, lu, ul, uu);
			if (lu <= ones) begin
				if (poss == 0)
					return failed;
				if (uu > poss - 1) uu = poss - 1;
				if (ul > uu)
					return failed;
			end
			if (ul >= poss) begin
				if (ll < ones + 1) ll = ones + 1;
				if (ll > lu)
					return failed;
			end
		end
		return settle(V_PEND, b, IMP_NONE, ll, lu, ul, uu);
	endfunction

	function void note(request_t rq);
		expected_q.push_back(propagate_step(rq));
	endfunction

	function int pending();
		return expected_q.size();
	endfunction

	// Print one line per mismatch, capping the log
	task report(string msg);
		if (errors < 100)
			$display("MISMATCH @%0t: %s", $time, msg);
		errors++;
	endtask

	task cmp_field(string name, logic [15:0] got, logic [15:0] want);
		if (got !== want)
			report($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	// Compare a result beat against the oldest expectation
	task check(result_t got);
		result_t want;
		if (expected_q.size() == 0) begin
			report("result beat with nothing expected");
			return;
		end
		want = expected_q.pop_front();
		cmp_field("verdict", 16'(got.verdict), 16'(want.verdict));
		cmp_field("flag_result", 16'(got.flag), 16'(want.flag));
		cmp_field("impose", 16'(got.impose), 16'(want.impose));
		cmp_field("low_min_out", got.low_min, want.low_min);
		cmp_field("low_max_out", got.low_max, want.low_max);
		cmp_field("up_min_out", got.up_min, want.up_min);
		cmp_field("up_max_out", got.up_max, want.up_max);
	endtask
endclass

module tb_reified_cardinality_propagator_unit;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [63:0] fixed_mask;
	logic [63:0] value_mask;
	logic [6:0]  var_count;
	logic [15:0] low_min;
	logic [15:0] low_max;
	logic [15:0] up_min;
	logic [15:0] up_max;
	logic [1:0]  flag_state;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  verdict;
	logic [1:0]  flag_result;
	logic [1:0]  impose;
	logic [15:0] low_min_out;
	logic [15:0] low_max_out;
	logic [15:0] up_min_out;
	logic [15:0] up_max_out;

	propagation_checker sb;
	bit recv_rush = 1'b0;
	bit hold_long = 1'b0;

	reified_cardinality_propagator_unit DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.fixed_mask  (fixed_mask),
		.value_mask  (value_mask),
		.var_count   (var_count),
		.low_min     (low_min),
		.low_max     (low_max),
		.up_min      (up_min),
		.up_max      (up_max),
		.flag_state  (flag_state),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.verdict     (verdict),
		.flag_result (flag_result),
		.impose      (impose),
		.low_min_out (low_min_out),
		.low_max_out (low_max_out),
		.up_min_out  (up_min_out),
		.up_max_out  (up_max_out)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Note accepted requests, then check accepted results
	always @(posedge clk) begin
		request_t rq;
		result_t  got;
		if (arst_n === 1'b1) begin
			if (in_valid === 1'b1 && in_stall === 1'b0) begin
				rq.fixed_bits = fixed_mask;
				rq.value_bits = value_mask;
				rq.count      = var_count;
				rq.lo_min     = low_min;
				rq.lo_max     = low_max;
				rq.hi_min     = up_min;
				rq.hi_max     = up_max;
				rq.flag       = flag_state;
				sb.note(rq);
			end
			if (out_valid === 1'b1 && out_stall === 1'b0) begin
				got.verdict = verdict;
				got.flag    = flag_result;
				got.impose  = impose;
				got.low_min = low_min_out;
				got.low_max = low_max_out;
				got.up_min  = up_min_out;
				got.up_max  = up_max_out;
				sb.check(got);
			end
		end
	end

	// Offer one request beat after a drawn gap and hold it until taken
	task automatic offer(input request_t rq, input bit eager);
		int gap;
		gap = eager ? 0 : ($urandom_range(0, 1) ? 0 : $urandom_range(1, 16));
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		fixed_mask <= rq.fixed_bits;
		value_mask <= rq.value_bits;
		var_count  <= rq.count;
		low_min    <= rq.lo_min;
		low_max    <= rq.lo_max;
		up_min     <= rq.hi_min;
		up_max     <= rq.hi_max;
		flag_state <= rq.flag;
		in_valid   <= 1'b1;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic directed(input logic [63:0] fb, input logic [63:0] vb,
		input logic [6:0] c, input logic [15:0] lmin, input logic [15:0] lmax,
		input logic [15:0] umin, input logic [15:0] umax, input logic [1:0] fl);
		request_t rq;
		rq = '{fb, vb, c, lmin, lmax, umin, umax, fl};
		offer(rq, 1'b0);
	endtask

	// Mostly well-formed requests with bounds near the counts; the rest is noise
	function automatic request_t random_request();
		request_t rq;
		int n, hi;
		logic [63:0] r0, r1;
		r0 = {$urandom, $urandom};
		r1 = {$urandom, $urandom};
		rq.value_bits = {$urandom, $urandom};
		if ($urandom_range(0, 9) == 0) begin
			rq.fixed_bits = r0;
			rq.count      = 7'($urandom_range(0, 127));
			rq.lo_min     = 16'($urandom_range(0, 65535));
			rq.lo_max     = 16'($urandom_range(0, 65535));
			rq.hi_min     = 16'($urandom_range(0, 65535));
			rq.hi_max     = 16'($urandom_range(0, 65535));
			rq.flag       = 2'($urandom_range(0, 3));
			return rq;
		end
		n = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 64);
		case ($urandom_range(0, 3))
			0: rq.fixed_bits = r0;
			1: rq.fixed_bits = r0 & r1;
			2: rq.fixed_bits = r0 | r1;
			default: rq.fixed_bits = '1;
		endcase
		hi = n + 2;
		rq.count  = 7'(n);
		rq.lo_min = 16'($urandom_range(0, hi));
		rq.lo_max = rq.lo_min + 16'($urandom_range(0, 4));
		rq.hi_min = 16'($urandom_range(0, hi));
		rq.hi_max = rq.hi_min + 16'($urandom_range(0, 4));
		// Occasionally hand over an empty interval
		if ($urandom_range(0, 19) == 0) begin
			rq.lo_max = rq.lo_min;
			rq.lo_min = rq.lo_min + 16'd1;
		end
		rq.flag = ($urandom_range(0, 15) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
		return rq;
	endfunction

	// Result side: draw a hold before each beat, with one long hold on request
	initial begin
		int hold;
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (hold_long) begin
				hold = 96;
				hold_long = 1'b0;
			end else if (recv_rush) begin
				hold = 0;
			end else begin
				hold = $urandom_range(0, 1) ? 0 : $urandom_range(1, 16);
			end
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(negedge clk);
				out_stall <= 1'b0;
			end
			@(posedge clk);
			while (out_valid !== 1'b1)
				@(posedge clk);
			@(negedge clk);
		end
	end

	// Stimulus and end of run
	initial begin
		request_t rq;
		int k;
		bit eager;
		sb = new();
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		fixed_mask = '0;
		value_mask = '0;
		var_count  = '0;
		low_min    = '0;
		low_max    = '0;
		up_min     = '0;
		up_max     = '0;
		flag_state = F_UNK;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// No variables
		directed('0, '0, 7'd0, 16'd0, 16'd5, 16'd0, 16'd5, F_UNK);
		// Too many variables, all fixed to one: entailed true
		directed('1, '1, 7'd127, 16'd64, 16'd64, 16'd64, 16'd64, F_UNK);
		// All fixed to zero with flag false: entailed, so failure
		directed('1, '0, 7'd64, 16'd0, 16'd0, 16'd0, 16'd0, F_FALSE);
		// Empty intervals given
		directed('0, '0, 7'd8, 16'd3, 16'd2, 16'd0, 16'd4, F_UNK);
		directed('0, '0, 7'd8, 16'd0, 16'd2, 16'd5, 16'd4, F_TRUE);
		// Unused flag code with low above up
		directed('0, '0, 7'd8, 16'd6, 16'd7, 16'd1, 16'd2, 2'd3);
		// Bounds at their greatest
		directed('0, '1, 7'd64, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, F_UNK);
		// Unused bits set above the count
		directed('1, '1, 7'd8, 16'd8, 16'd8, 16'd8, 16'd8, F_TRUE);
		// Flag true: fix the rest to zero, then to one
		directed(64'h7, 64'h7, 7'd10, 16'd0, 16'd3, 16'd3, 16'd3, F_TRUE);
		directed(64'h7, 64'h0, 7'd10, 16'd7, 16'd9, 16'd7, 16'd10, F_TRUE);
		// Flag true: narrow and stay pending
		directed('0, '0, 7'd10, 16'd0, 16'd20, 16'd0, 16'd30, F_TRUE);
		// Flag false: fix the rest to zero, then to one
		directed(64'h3, 64'h1, 7'd5, 16'd2, 16'd4, 16'd4, 16'd5, F_FALSE);
		directed(64'h1, 64'h1, 7'd5, 16'd0, 16'd1, 16'd4, 16'd6, F_FALSE);
		// Flag false: narrow up, then low, then surely inside, so failure
		directed('0, '0, 7'd6, 16'd0, 16'd0, 16'd2, 16'd9, F_FALSE);
		directed(64'h1, 64'h1, 7'd6, 16'd0, 16'd4, 16'd6, 16'd9, F_FALSE);
		directed(64'h1, 64'h1, 7'd6, 16'd0, 16'd1, 16'd6, 16'd9, F_FALSE);
		// Flag open: pending, too many ones, surely inside
		directed('0, '0, 7'd6, 16'd1, 16'd3, 16'd2, 16'd5, F_UNK);
		directed(64'hF, 64'hF, 7'd4, 16'd0, 16'd1, 16'd0, 16'd2, F_UNK);
		directed(64'hF, 64'h5, 7'd4, 16'd1, 16'd2, 16'd2, 16'd3, F_UNK);
		// Flag true with too many ones, flag false surely inside
		directed(64'hF, 64'hF, 7'd4, 16'd0, 16'd1, 16'd0, 16'd2, F_TRUE);
		directed(64'hF, 64'h5, 7'd4, 16'd1, 16'd2, 16'd2, 16'd3, F_FALSE);
		// Flag true: narrowing empties low
		directed('0, '0, 7'd8, 16'd5, 16'd9, 16'd1, 16'd3, F_TRUE);

		for (k = 0; k < 1100; k++) begin
			eager = ((k % 250) < 50) || (k >= 400 && k < 460);
			recv_rush = ((k % 300) >= 200) && ((k % 300) < 250);
			// Park the result side while the requests keep coming
			if (k == 400)
				hold_long = 1'b1;
			// Drain everything before carrying on
			if (k == 700) begin
				in_valid <= 1'b0;
				do @(negedge clk); while (sb.pending() != 0);
			end
			rq = random_request();
			offer(rq, eager);
		end
		in_valid <= 1'b0;

		do @(negedge clk); while (sb.pending() != 0);
		repeat (8) @(negedge clk);
		if (sb.errors == 0)
			$display("tb_reified_cardinality_propagator_unit: clean");
		else
			$display("tb_reified_cardinality_propagator_unit: errors");
		$finish;
	end

	// Give up after a generous fixed time
	initial begin
		#5_000_000;
		$display("tb_reified_cardinality_propagator_unit: errors");
		$finish;
	end

endmodule

// File: reified_cardinality_propagator_unit.f
design/rcp_pkg.sv
design/rcp_lane.sv
design/rcp_front.sv
design/rcp_merge.sv
design/reified_cardinality_propagator_unit.sv
tb/tb_reified_cardinality_propagator_unit.sv
